// File: hdl/prc_pkg.sv
// Shared types, constants and the microcode program for the pitch rate controller.
// Used by prc_seq, prc_dp and pitch_rate_pi_controller_top; depends on nothing.
package prc_pkg;

  // Field and datapath widths
  localparam int SP_W    = 16;
  localparam int SC_W    = 16;
  localparam int US_W    = 20;
  localparam int GAIN_W  = 24;
  localparam int LIM_W   = 18;
  localparam int ACT_W   = 16;
  localparam int INTEG_W = 19;
  localparam int RAW_W   = 32;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 63;
  localparam int SQ_W    = 20;
  localparam int INCM_W  = 33;
  localparam int CFG_IDX_W = 2;

  // Division of the integrator product by one million: drop the factor 2^6
  // by a shift, then long-divide by the odd part, DIV_BITS quotient bits a step.
  localparam int DIV_W        = 48;
  localparam int REM_W        = 14;
  localparam int DIV_SHIFT    = 6;
  localparam int DIV_BITS     = 4;
  localparam int DIV_ITERS    = DIV_W / DIV_BITS;
  localparam int LOOP_W       = $clog2(DIV_ITERS);
  localparam logic [REM_W:0] DIV_ODD = 15'd15625;
  localparam logic [52:0] US_HALF_SEC_BIAS = 53'd500000;

  localparam logic [US_W-1:0] LONG_INTERVAL_US = 20'd500000;
  localparam logic [LIM_W-1:0] LIMIT_MAX = 18'd131072;
  localparam logic signed [RAW_W-1:0] RAW_ONE = 32'sd16384;
  localparam logic signed [ACT_W-1:0] ACT_ONE = 16'sd16384;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 19'sd131072;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIM = 2'd3;

  // Datapath operations, one per control word
  typedef enum logic [4:0] {
    OP_NOP,
    OP_ERR,
    OP_MUL_SQ,
    OP_SQ_RND,
    OP_MUL_ES,
    OP_MUL_M,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_MUL_INC,
    OP_INC_RND,
    OP_INTEG,
    OP_MUL_FS,
    OP_MUL_FF,
    OP_ACC_FF,
    OP_MUL_ES2,
    OP_MUL_PR,
    OP_ACC_PR,
    OP_ACC_INT,
    OP_ABS,
    OP_ROUND,
    OP_RAW,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_INVALID,
    JMP_NOGATE,
    JMP_LOOP
  } jmp_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  localparam int STEP_W = 5;

  typedef struct packed {
    op_t               op;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  // Status from datapath to sequencer for conditional jumps
  typedef struct packed {
    logic item_valid;
    logic integrate;
  } dp_status_t;

  localparam logic [STEP_W-1:0] STEP_DIV  = 5'd6;
  localparam logic [STEP_W-1:0] STEP_FF   = 5'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT = 5'd20;
  localparam logic [STEP_W-1:0] STEP_NONE = 5'd0;

  function automatic ucode_t uw(input op_t op, input jmp_t jmp,
                                input logic [STEP_W-1:0] target, input logic last);
    ucode_t w;
    w.op     = op;
    w.jmp    = jmp;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // Control store: one word per program address
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      5'd0:  w = uw(OP_ERR,      JMP_INVALID, STEP_EMIT, 1'b0);
      5'd1:  w = uw(OP_MUL_SQ,   JMP_NONE,    STEP_NONE, 1'b0);
      5'd2:  w = uw(OP_SQ_RND,   JMP_NOGATE,  STEP_FF,   1'b0);
      5'd3:  w = uw(OP_MUL_ES,   JMP_NONE,    STEP_NONE, 1'b0);
      5'd4:  w = uw(OP_MUL_M,    JMP_NONE,    STEP_NONE, 1'b0);
      5'd5:  w = uw(OP_DIV_LOAD, JMP_NONE,    STEP_NONE, 1'b0);
      5'd6:  w = uw(OP_DIV_STEP, JMP_LOOP,    STEP_DIV,  1'b0);
      5'd7:  w = uw(OP_MUL_INC,  JMP_NONE,    STEP_NONE, 1'b0);
      5'd8:  w = uw(OP_INC_RND,  JMP_NONE,    STEP_NONE, 1'b0);
      5'd9:  w = uw(OP_INTEG,    JMP_NONE,    STEP_NONE, 1'b0);
      5'd10: w = uw(OP_MUL_FS,   JMP_NONE,    STEP_NONE, 1'b0);
      5'd11: w = uw(OP_MUL_FF,   JMP_NONE,    STEP_NONE, 1'b0);
      5'd12: w = uw(OP_ACC_FF,   JMP_NONE,    STEP_NONE, 1'b0);
      5'd13: w = uw(OP_MUL_ES2,  JMP_NONE,    STEP_NONE, 1'b0);
      5'd14: w = uw(OP_MUL_PR,   JMP_NONE,    STEP_NONE, 1'b0);
      5'd15: w = uw(OP_ACC_PR,   JMP_NONE,    STEP_NONE, 1'b0);
      5'd16: w = uw(OP_ACC_INT,  JMP_NONE,    STEP_NONE, 1'b0);
      5'd17: w = uw(OP_ABS,      JMP_NONE,    STEP_NONE, 1'b0);
      5'd18: w = uw(OP_ROUND,    JMP_NONE,    STEP_NONE, 1'b0);
      5'd19: w = uw(OP_RAW,      JMP_NONE,    STEP_NONE, 1'b0);
      5'd20: w = uw(OP_EMIT,     JMP_NONE,    STEP_NONE, 1'b1);
      default: w = uw(OP_NOP,    JMP_NONE,    STEP_NONE, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// File: hdl/prc_seq.sv
// Microcode sequencer: step counter, loop counter and conditional jumps.
// Reads the control store in prc_pkg; drives the operation of prc_dp.
module prc_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   emit_ok,
  input  prc_pkg::dp_status_t    status,
  output prc_pkg::op_t           op,
  output logic                   busy
);

  prc_pkg::seq_state_t              state_r, state_nxt;
  logic [prc_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [prc_pkg::LOOP_W-1:0]       loop_r, loop_nxt;
  prc_pkg::ucode_t                  word;
  logic                             take;
  logic                             hold;

  assign word = prc_pkg::ucode_rom(step_r);
  assign busy = (state_r == prc_pkg::SEQ_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prc_pkg::SEQ_IDLE;
      step_r  <= '0;
      loop_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      loop_r  <= loop_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    loop_nxt  = loop_r;
    op        = prc_pkg::OP_NOP;
    take      = 1'b0;
    hold      = 1'b0;
    case (word.jmp)
      prc_pkg::JMP_NONE:    take = 1'b0;
      prc_pkg::JMP_INVALID: take = !status.item_valid;
      prc_pkg::JMP_NOGATE:  take = !status.integrate;
      prc_pkg::JMP_LOOP:    take = (loop_r != prc_pkg::LOOP_W'(prc_pkg::DIV_ITERS - 1));
      default:              take = 1'b0;
    endcase
    case (state_r)
      prc_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt = prc_pkg::SEQ_RUN;
          step_nxt  = '0;
        end
      end
      prc_pkg::SEQ_RUN: begin
        // wait on the result slot before the final step
        hold = (word.op == prc_pkg::OP_EMIT) && !emit_ok;
        if (!hold) begin
          op = word.op;
          if (word.jmp == prc_pkg::JMP_LOOP) begin
            loop_nxt = take ? loop_r + 1'b1 : '0;
          end
          if (word.last) begin
            state_nxt = prc_pkg::SEQ_IDLE;
            step_nxt  = '0;
          end else if (take) begin
            step_nxt = word.target;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: state_nxt = prc_pkg::SEQ_IDLE;
    endcase
  end

  a_idle_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prc_pkg::SEQ_IDLE) |-> (step_r == '0 && loop_r == '0))
    else $error("sequencer idle away from program start");

  a_loop_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (loop_r != '0) |-> (word.op == prc_pkg::OP_DIV_STEP))
    else $error("loop count live outside the division step");

endmodule

// File: hdl/prc_dp.sv
// Datapath: operand registers, one shared multiplier, long divider, accumulator
// and controller state. One op a cycle from prc_seq unless held; uses prc_pkg.
module prc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic signed [prc_pkg::SP_W-1:0]   rate_setpoint,
  input  logic signed [prc_pkg::SP_W-1:0]   measured_rate,
  input  logic [prc_pkg::SC_W-1:0]          airspeed_scale,
  input  logic [prc_pkg::US_W-1:0]          elapsed_us,
  input  logic                              hold_integrator,
  input  logic                              inputs_valid,
  input  logic [prc_pkg::GAIN_W-1:0]        gain_p,
  input  logic [prc_pkg::GAIN_W-1:0]        gain_i,
  input  logic [prc_pkg::GAIN_W-1:0]        gain_ff,
  input  logic [prc_pkg::LIM_W-1:0]         int_limit,
  input  prc_pkg::op_t                      op,
  output prc_pkg::dp_status_t               status,
  output logic signed [prc_pkg::ACT_W-1:0]  actuator_command,
  output logic signed [prc_pkg::INTEG_W-1:0] integrator_value,
  output logic                              step_skipped
);

  // item registers
  logic signed [prc_pkg::SP_W-1:0]    sp_r, sp_nxt;
  logic signed [prc_pkg::SP_W-1:0]    meas_r, meas_nxt;
  logic [prc_pkg::SC_W-1:0]           sc_r, sc_nxt;
  logic [prc_pkg::US_W-1:0]           us_r, us_nxt;
  logic                               hold_r, hold_nxt;
  logic                               valid_r, valid_nxt;
  // working registers
  logic [prc_pkg::SP_W-1:0]           emag_r, emag_nxt;
  logic                               eneg_r, eneg_nxt;
  logic [prc_pkg::SP_W-1:0]           abssp_r, abssp_nxt;
  logic                               spneg_r, spneg_nxt;
  logic                               gate_r, gate_nxt;
  logic [prc_pkg::SQ_W-1:0]           sq_r, sq_nxt;
  logic [prc_pkg::PROD_W-1:0]         p_r, p_nxt;
  logic [prc_pkg::DIV_W-1:0]          div_r, div_nxt;
  logic [prc_pkg::REM_W-1:0]          rem_r, rem_nxt;
  logic [prc_pkg::INCM_W-1:0]         incm_r, incm_nxt;
  logic signed [prc_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic                               accneg_r, accneg_nxt;
  logic [prc_pkg::RAW_W-1:0]          qmag_r, qmag_nxt;
  // controller state
  logic signed [prc_pkg::INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [prc_pkg::RAW_W-1:0]   rawout_r, rawout_nxt;

  logic [prc_pkg::MUL_A_W-1:0]        mul_a;
  logic [prc_pkg::MUL_B_W-1:0]        mul_b;
  logic [prc_pkg::PROD_W-1:0]         mul_prod;

  logic [prc_pkg::REM_W:0]            dv_trial;
  logic [prc_pkg::REM_W-1:0]          dv_rem;
  logic [prc_pkg::DIV_W-1:0]          dv_quo;

  logic signed [prc_pkg::SP_W:0]      err_v;
  logic [prc_pkg::SP_W:0]             err_mag;
  logic [prc_pkg::SP_W:0]             sp_mag;
  logic [32:0]                        sq_sum;
  logic [52:0]                        dl_sum;
  logic [56:0]                        inc_sum;
  logic [prc_pkg::LIM_W-1:0]          lim;
  logic                               windup;
  logic signed [35:0]                 integ_ext;
  logic signed [35:0]                 incm_ext;
  logic signed [35:0]                 integ_sum;
  logic signed [35:0]                 lim_pos;
  logic signed [prc_pkg::ACC_W-1:0]   p_ext;
  logic [prc_pkg::ACC_W-1:0]          rnd_sum;
  logic [36:0]                        q_full;
  logic [36:0]                        q_cap;

  assign status.item_valid = valid_r;
  assign status.integrate  = gate_r;

  // shared unsigned multiplier, operands chosen by the operation
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      prc_pkg::OP_MUL_SQ:  begin mul_a = 36'(sc_r);         mul_b = 24'(sc_r);   end
      prc_pkg::OP_MUL_ES:  begin mul_a = 36'(emag_r);       mul_b = 24'(sc_r);   end
      prc_pkg::OP_MUL_M:   begin mul_a = 36'(p_r[31:0]);    mul_b = 24'(us_r);   end
      prc_pkg::OP_MUL_INC: begin mul_a = 36'(div_r[31:0]);  mul_b = gain_i;      end
      prc_pkg::OP_MUL_FS:  begin mul_a = 36'(abssp_r);      mul_b = 24'(sc_r);   end
      prc_pkg::OP_MUL_FF:  begin mul_a = 36'(p_r[31:0]);    mul_b = gain_ff;     end
      prc_pkg::OP_MUL_ES2: begin mul_a = 36'(emag_r);       mul_b = 24'(sq_r);   end
      prc_pkg::OP_MUL_PR:  begin mul_a = p_r[35:0];         mul_b = gain_p;      end
      default:             begin mul_a = '0;                mul_b = '0;          end
    endcase
    mul_prod = mul_a * mul_b;
  end

  // restoring division by the odd part of one million, DIV_BITS quotient bits
  always_comb begin
    dv_rem   = rem_r;
    dv_quo   = div_r;
    dv_trial = '0;
    for (int k = 0; k < prc_pkg::DIV_BITS; k++) begin
      dv_trial = {dv_rem, dv_quo[prc_pkg::DIV_W-1]};
      dv_quo   = {dv_quo[prc_pkg::DIV_W-2:0], 1'b0};
      if (dv_trial >= prc_pkg::DIV_ODD) begin
        dv_trial  = dv_trial - prc_pkg::DIV_ODD;
        dv_quo[0] = 1'b1;
      end
      dv_rem = dv_trial[prc_pkg::REM_W-1:0];
    end
  end

  always_comb begin
    err_v     = $signed({sp_r[prc_pkg::SP_W-1], sp_r}) - $signed({meas_r[prc_pkg::SP_W-1], meas_r});
    err_mag   = err_v[prc_pkg::SP_W] ? (~err_v + 1'b1) : err_v;
    sp_mag    = sp_r[prc_pkg::SP_W-1] ? (~{1'b1, sp_r} + 1'b1) : {1'b0, sp_r};
    sq_sum    = {1'b0, p_r[31:0]} + 33'd2048;
    dl_sum    = {1'b0, p_r[51:0]} + prc_pkg::US_HALF_SEC_BIAS;
    inc_sum   = {1'b0, p_r[55:0]} + 57'(24'h800000);
    lim       = (int_limit > prc_pkg::LIMIT_MAX) ? prc_pkg::LIMIT_MAX : int_limit;
    windup    = (eneg_r && (rawout_r < -prc_pkg::RAW_ONE)) ||
                (!eneg_r && (rawout_r > prc_pkg::RAW_ONE));
    integ_ext = $signed({{17{integ_r[prc_pkg::INTEG_W-1]}}, integ_r});
    incm_ext  = $signed({3'b000, incm_r});
    lim_pos   = $signed({18'd0, lim});
    if (windup) begin
      integ_sum = integ_ext;
    end else if (eneg_r) begin
      integ_sum = integ_ext - incm_ext;
    end else begin
      integ_sum = integ_ext + incm_ext;
    end
    p_ext   = $signed({3'b000, p_r});
    rnd_sum = acc_r + 63'(26'h2000000);
    q_full  = rnd_sum[62:26];
    q_cap   = accneg_r ? 37'h0080000000 : 37'h007FFFFFFF;
  end

  always_comb begin
    sp_nxt     = sp_r;
    meas_nxt   = meas_r;
    sc_nxt     = sc_r;
    us_nxt     = us_r;
    hold_nxt   = hold_r;
    valid_nxt  = valid_r;
    emag_nxt   = emag_r;
    eneg_nxt   = eneg_r;
    abssp_nxt  = abssp_r;
    spneg_nxt  = spneg_r;
    gate_nxt   = gate_r;
    sq_nxt     = sq_r;
    p_nxt      = p_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    incm_nxt   = incm_r;
    acc_nxt    = acc_r;
    accneg_nxt = accneg_r;
    qmag_nxt   = qmag_r;
    integ_nxt  = integ_r;
    rawout_nxt = rawout_r;
    if (load) begin
      sp_nxt    = rate_setpoint;
      meas_nxt  = measured_rate;
      sc_nxt    = airspeed_scale;
      us_nxt    = elapsed_us;
      hold_nxt  = hold_integrator;
      valid_nxt = inputs_valid;
    end
    case (op)
      prc_pkg::OP_ERR: begin
        emag_nxt  = err_mag[prc_pkg::SP_W-1:0];
        eneg_nxt  = err_v[prc_pkg::SP_W];
        abssp_nxt = sp_mag[prc_pkg::SP_W-1:0];
        spneg_nxt = sp_r[prc_pkg::SP_W-1];
        gate_nxt  = !hold_r && (gain_i != '0) && (us_r <= prc_pkg::LONG_INTERVAL_US);
      end
      prc_pkg::OP_MUL_SQ, prc_pkg::OP_MUL_ES, prc_pkg::OP_MUL_M, prc_pkg::OP_MUL_INC,
      prc_pkg::OP_MUL_FS, prc_pkg::OP_MUL_FF, prc_pkg::OP_MUL_ES2, prc_pkg::OP_MUL_PR:
        p_nxt = mul_prod;
      prc_pkg::OP_SQ_RND: sq_nxt = sq_sum[31:12];
      prc_pkg::OP_DIV_LOAD: begin
        div_nxt = {1'b0, dl_sum[52:prc_pkg::DIV_SHIFT]};
        rem_nxt = '0;
      end
      prc_pkg::OP_DIV_STEP: begin
        div_nxt = dv_quo;
        rem_nxt = dv_rem;
      end
      prc_pkg::OP_INC_RND: incm_nxt = inc_sum[56:24];
      prc_pkg::OP_INTEG: begin
        if (integ_sum > lim_pos) begin
          integ_nxt = prc_pkg::INTEG_W'(lim_pos);
        end else if (integ_sum < -lim_pos) begin
          integ_nxt = prc_pkg::INTEG_W'(-lim_pos);
        end else begin
          integ_nxt = prc_pkg::INTEG_W'(integ_sum);
        end
      end
      prc_pkg::OP_ACC_FF:  acc_nxt = spneg_r ? -p_ext : p_ext;
      prc_pkg::OP_ACC_PR:  acc_nxt = eneg_r ? (acc_r - p_ext) : (acc_r + p_ext);
      prc_pkg::OP_ACC_INT:
        acc_nxt = acc_r + $signed({{20{integ_r[prc_pkg::INTEG_W-1]}}, integ_r, 24'd0});
      prc_pkg::OP_ABS: begin
        accneg_nxt = acc_r[prc_pkg::ACC_W-1];
        acc_nxt    = acc_r[prc_pkg::ACC_W-1] ? -acc_r : acc_r;
      end
      prc_pkg::OP_ROUND: qmag_nxt = (q_full > q_cap) ? q_cap[31:0] : q_full[31:0];
      prc_pkg::OP_RAW:   rawout_nxt = accneg_r ? $signed(~qmag_r + 1'b1) : $signed(qmag_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r  <= '0;
      rawout_r <= '0;
      valid_r  <= 1'b0;
      gate_r   <= 1'b0;
    end else begin
      integ_r  <= integ_nxt;
      rawout_r <= rawout_nxt;
      valid_r  <= valid_nxt;
      gate_r   <= gate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r     <= sp_nxt;
    meas_r   <= meas_nxt;
    sc_r     <= sc_nxt;
    us_r     <= us_nxt;
    hold_r   <= hold_nxt;
    emag_r   <= emag_nxt;
    eneg_r   <= eneg_nxt;
    abssp_r  <= abssp_nxt;
    spneg_r  <= spneg_nxt;
    sq_r     <= sq_nxt;
    p_r      <= p_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    incm_r   <= incm_nxt;
    acc_r    <= acc_nxt;
    accneg_r <= accneg_nxt;
    qmag_r   <= qmag_nxt;
  end

  always_comb begin
    if (rawout_r > prc_pkg::RAW_ONE) begin
      actuator_command = prc_pkg::ACT_ONE;
    end else if (rawout_r < -prc_pkg::RAW_ONE) begin
      actuator_command = -prc_pkg::ACT_ONE;
    end else begin
      actuator_command = rawout_r[prc_pkg::ACT_W-1:0];
    end
  end

  assign integrator_value = integ_r;
  assign step_skipped     = !valid_r;

  a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= prc_pkg::INTEG_MAX) && (integ_r >= -prc_pkg::INTEG_MAX))
    else $error("integrator outside its clamp range");

endmodule

// File: hdl/pitch_rate_pi_controller_top.sv
// Top level of the pitch body-rate PI controller with feedforward and anti-windup.
// Instantiates prc_seq and prc_dp; uses prc_pkg for types and constants.
//
//   channel  direction  handshake            request contents
//   in_      input      in_valid / in_stall  setpoint, measured rate, scaler, dt, flags
//   out_     output     out_valid/out_stall  actuator command, integrator, skip flag
//   cfg_     input      cfg_we               register index and write data
//
// One request at a time: in_stall is high while the sequencer runs. A request
// occupies the sequencer for the fewest steps when invalid, more when the
// integrator is frozen and the most when it integrates; the long division
// by one million (12 passes of 4 quotient bits) takes the largest share.
// Reset (rst_n low, synchronous) clears gains, integrator and stored command.
// A stalled result holds in the output register; the sequencer waits at its
// final step until the slot frees, and a new request is taken only once it is idle.
module pitch_rate_pi_controller_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [prc_pkg::SP_W-1:0]      in_rate_setpoint,
  input  logic signed [prc_pkg::SP_W-1:0]      in_measured_rate,
  input  logic [prc_pkg::SC_W-1:0]             in_airspeed_scale,
  input  logic [prc_pkg::US_W-1:0]             in_elapsed_us,
  input  logic                                 in_hold_integrator,
  input  logic                                 in_inputs_valid,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [prc_pkg::ACT_W-1:0]     out_actuator_command,
  output logic signed [prc_pkg::INTEG_W-1:0]   out_integrator_value,
  output logic                                 out_step_skipped,
  // configuration
  input  logic                                 cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prc_pkg::GAIN_W-1:0]           cfg_wdata
);

  logic [prc_pkg::GAIN_W-1:0]          gain_p_r, gain_p_nxt;
  logic [prc_pkg::GAIN_W-1:0]          gain_i_r, gain_i_nxt;
  logic [prc_pkg::GAIN_W-1:0]          gain_ff_r, gain_ff_nxt;
  logic [prc_pkg::LIM_W-1:0]           int_lim_r, int_lim_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [prc_pkg::ACT_W-1:0]    out_act_r, out_act_nxt;
  logic signed [prc_pkg::INTEG_W-1:0]  out_integ_r, out_integ_nxt;
  logic                                out_skip_r, out_skip_nxt;

  logic                                seq_busy;
  logic                                in_take;
  logic                                emit_ok;
  prc_pkg::op_t                        seq_op;
  prc_pkg::dp_status_t                 dp_status;
  logic signed [prc_pkg::ACT_W-1:0]    dp_act;
  logic signed [prc_pkg::INTEG_W-1:0]  dp_integ;
  logic                                dp_skip;

  // take a request only while the sequencer is idle
  assign in_stall = seq_busy;
  assign in_take  = in_valid && !seq_busy;
  // the result slot is free when empty or being drained this cycle
  assign emit_ok  = !out_valid_r || !out_stall;

  prc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_take),
    .emit_ok (emit_ok),
    .status  (dp_status),
    .op      (seq_op),
    .busy    (seq_busy)
  );

  prc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_take),
    .rate_setpoint    (in_rate_setpoint),
    .measured_rate    (in_measured_rate),
    .airspeed_scale   (in_airspeed_scale),
    .elapsed_us       (in_elapsed_us),
    .hold_integrator  (in_hold_integrator),
    .inputs_valid     (in_inputs_valid),
    .gain_p           (gain_p_r),
    .gain_i           (gain_i_r),
    .gain_ff          (gain_ff_r),
    .int_limit        (int_lim_r),
    .op               (seq_op),
    .status           (dp_status),
    .actuator_command (dp_act),
    .integrator_value (dp_integ),
    .step_skipped     (dp_skip)
  );

  // configuration writes: mask each register to its own width
  always_comb begin
    gain_p_nxt  = gain_p_r;
    gain_i_nxt  = gain_i_r;
    gain_ff_nxt = gain_ff_r;
    int_lim_nxt = int_lim_r;
    if (cfg_we) begin
      case (cfg_index)
        prc_pkg::CFG_GAIN_P:  gain_p_nxt  = cfg_wdata;
        prc_pkg::CFG_GAIN_I:  gain_i_nxt  = cfg_wdata;
        prc_pkg::CFG_GAIN_FF: gain_ff_nxt = cfg_wdata;
        prc_pkg::CFG_INT_LIM: int_lim_nxt = cfg_wdata[prc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // result register: load on the final program step, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_act_nxt   = out_act_r;
    out_integ_nxt = out_integ_r;
    out_skip_nxt  = out_skip_r;
    if (seq_op == prc_pkg::OP_EMIT) begin
      out_valid_nxt = 1'b1;
      out_act_nxt   = dp_act;
      out_integ_nxt = dp_integ;
      out_skip_nxt  = dp_skip;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_ff_r   <= '0;
      int_lim_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_ff_r   <= gain_ff_nxt;
      int_lim_r   <= int_lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_act_r   <= out_act_nxt;
    out_integ_r <= out_integ_nxt;
    out_skip_r  <= out_skip_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_actuator_command = out_act_r;
  assign out_integrator_value = out_integ_r;
  assign out_step_skipped     = out_skip_r;

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_op == prc_pkg::OP_EMIT) |-> (!out_valid_r || !out_stall))
    else $error("result written over a held result");

endmodule
